// File: hdl/drnm_pkg.sv
package drnm_pkg;

    // item field widths
    localparam int OP_W       = 2;
    localparam int ETA_W      = 14;
    localparam int PHI_W      = 13;
    localparam int PT_W       = 16;
    localparam int OUT_IDX_W  = 6;

    // stream bus widths
    localparam int S_DATA_W   = 48;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 8;
    localparam int M_USER_W   = 1;

    // configuration registers
    localparam int CUT_W      = 29;
    localparam int ACC_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 29;

    localparam logic [CUT_W-1:0] MAX_DR2_RESET = CUT_W'(104857600);
    localparam logic [PT_W-1:0]  MIN_PT_RESET  = '0;
    localparam logic [ACC_W-1:0] ETA_ACC_RESET = ACC_W'(2150);

    // distance arithmetic: |deta| and folded |dphi| both stay below 2^14
    localparam int DIST_W     = 14;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int D2_W       = SQ_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_MATCH     = 2'd1,
        OP_CLR_USED  = 2'd2,
        OP_CLR_TABLE = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DR2 = 2'd0,
        REG_MIN_PT  = 2'd1,
        REG_ETA_ACC = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CUT_W-1:0] max_dr2;
        logic [PT_W-1:0]  min_pt;
        logic [ACC_W-1:0] eta_acc;
    } cfg_t;

    // entry data for a load, or the query position for a match
    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic [PT_W-1:0]         pt;
    } bcast_t;

    typedef struct packed {
        logic load;
        logic clr_used;
        logic clr_table;
        logic set_used;
    } cell_ctl_t;

    // running best candidate handed along the chain
    typedef struct packed {
        logic            have;
        logic [D2_W-1:0] d2;
    } token_t;

endpackage

// File: hdl/delta_r_exclusive_nearest_match_unit.sv
// Delta-R exclusive nearest match.
// Input stream (s_axis): one item per command. tuser carries the opcode:
// load entry, match query, clear used marks, clear table. tdata carries
// eta, phi and pt. Output stream (m_axis): one item per match query only,
// tuser = match found flag, tdata = matched table index (0 when none).
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
// index 0 max_dr_squared, 1 min_pt, 2 eta_acceptance; other indexes ignored.
// Write config only while the unit is idle.
// Timing: a load or clear leaves the unit idle, so s_axis_tready stays high.
// A match query passes from accept through the per-cell distance pipeline
// (absolute differences, squares, squared distance and cut), then the running
// best walks the chain of cells one cell per cycle, and finally the result is
// loaded into the output register.
// Only one query is in flight; the next item can be taken in the cycle after
// the result is registered.
// Reset: table empty, all used marks clear, config registers at defaults.
// Stall: a delivered result sits in the output register until taken; loads
// and clears are still accepted meanwhile. A query finishing while the
// output register is full waits, holding s_axis_tready low, until it drains.
module delta_r_exclusive_nearest_match_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int HALF_TURN   = 3217
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [drnm_pkg::S_DATA_W-1:0]       s_axis_tdata,  // eta[13:0], phi[26:14], pt[42:27]
    input  logic [drnm_pkg::S_USER_W-1:0]       s_axis_tuser,  // opcode[1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [drnm_pkg::M_DATA_W-1:0]       m_axis_tdata,  // match_index[5:0]
    output logic [drnm_pkg::M_USER_W-1:0]       m_axis_tuser,  // match_found[0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drnm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drnm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import drnm_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_LAST = TABLE_DEPTH + 2;
    localparam int SC_W      = $clog2(SCAN_LAST + 1);

    state_t            state_reg, state_next;
    logic [SC_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    cfg_t              cfg_reg, cfg_next;
    bcast_t            bus_reg;
    cell_ctl_t         ctl_reg, ctl_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;

    logic              in_acc;
    logic              is_query;
    logic              finish_take;
    opcode_t           op;

    token_t            tok_ch [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  idx_ch [0:TABLE_DEPTH];

    assign op       = opcode_t'(s_axis_tuser);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_query = (op == OP_MATCH);

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAX_DR2: cfg_next.max_dr2 = cfg_data[CUT_W-1:0];
                REG_MIN_PT:  cfg_next.min_pt  = cfg_data[PT_W-1:0];
                REG_ETA_ACC: cfg_next.eta_acc = cfg_data[ACC_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_dr2 <= MAX_DR2_RESET;
            cfg_reg.min_pt  <= MIN_PT_RESET;
            cfg_reg.eta_acc <= ETA_ACC_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc && is_query)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (cnt_reg == SC_W'(SCAN_LAST))
                    state_next = ST_FINISH;
            ST_FINISH:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        finish_take   = 1'b0;
        cnt_next      = '0;
        case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_SCAN:
                cnt_next = cnt_reg + SC_W'(1);
            ST_FINISH:
                finish_take = !out_valid_reg || m_axis_tready;
            default:
                s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ---------------- commands to the cells (applied in the cycle after accept or finish) ----
    always_comb
    begin
        ctl_next          = '0;
        tgt_next          = tgt_reg;
        if (in_acc)
        begin
            case (op)
                OP_LOAD:      ctl_next.load = 1'b1;
                OP_CLR_USED:  ctl_next.clr_used = 1'b1;
                OP_CLR_TABLE:
                begin
                    ctl_next.clr_used  = 1'b1;
                    ctl_next.clr_table = 1'b1;
                end
                default:      ctl_next = '0;
            endcase
        end
        if (finish_take && tok_ch[TABLE_DEPTH].have)
        begin
            ctl_next.set_used = 1'b1;
            tgt_next          = idx_ch[TABLE_DEPTH];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl_reg.clr_table)
            count_next = '0;
        else if (ctl_reg.load && (count_reg < CNT_W'(TABLE_DEPTH)))
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            count_reg <= '0;
            tgt_reg   <= '0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            count_reg <= count_next;
            tgt_reg   <= tgt_next;
        end
    end

    // broadcast bus: load data or query position
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            bus_reg.eta <= s_axis_tdata[ETA_W-1:0];
            bus_reg.phi <= s_axis_tdata[ETA_W+PHI_W-1:ETA_W];
            bus_reg.pt  <= s_axis_tdata[ETA_W+PHI_W+PT_W-1:ETA_W+PHI_W];
        end
    end

    // ---------------- chain of cells ----------------
    assign tok_ch[0] = '0;
    assign idx_ch[0] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        drnm_cell #(
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .CELL_IDX  (i),
            .HALF_TURN (HALF_TURN)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .bus     (bus_reg),
            .ctl     (ctl_reg),
            .tgt_idx (tgt_reg),
            .count   (count_reg),
            .tok_in  (tok_ch[i]),
            .idx_in  (idx_ch[i]),
            .tok_out (tok_ch[i+1]),
            .idx_out (idx_ch[i+1])
        );
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish_take)
        begin
            out_found_reg <= tok_ch[TABLE_DEPTH].have;
            out_idx_reg   <= tok_ch[TABLE_DEPTH].have ?
                             OUT_IDX_W'(idx_ch[TABLE_DEPTH]) : '0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_found_reg;
    assign m_axis_tdata    = M_DATA_W'(out_idx_reg);

    // ---------------- checks ----------------
    a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_query) |=> (state_reg == ST_SCAN))
        else $error("accepted query did not start a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result appeared without a finished scan");

    a_no_match_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (out_idx_reg == '0))
        else $error("nonzero index on a miss");

endmodule

// File: hdl/drnm_cell.sv
module drnm_cell #(
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7,
    parameter int CELL_IDX  = 0,
    parameter int HALF_TURN = 3217
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drnm_pkg::cfg_t      cfg,
    input  drnm_pkg::bcast_t    bus,
    input  drnm_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]    tgt_idx,
    input  logic [CNT_W-1:0]    count,
    input  drnm_pkg::token_t    tok_in,
    input  logic [IDX_W-1:0]    idx_in,
    output drnm_pkg::token_t    tok_out,
    output logic [IDX_W-1:0]    idx_out
);
    import drnm_pkg::*;

    localparam int EW1 = ETA_W + 1;
    localparam int PW1 = PHI_W + 1;
    localparam int TW  = $clog2(2 * HALF_TURN + 1);
    localparam int FW  = ((TW > DIST_W) ? TW : DIST_W) + 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    logic signed [ETA_W-1:0] e_eta_reg;
    logic signed [PHI_W-1:0] e_phi_reg;
    logic [PT_W-1:0]         e_pt_reg;
    logic                    used_reg;
    logic                    used_next;

    logic signed [EW1-1:0]   de;
    logic signed [PW1-1:0]   dp;
    logic [EW1-1:0]          de_mag;
    logic [PW1-1:0]          dp_mag;
    logic signed [FW-1:0]    dpx;
    logic signed [FW-1:0]    fold_v;
    logic signed [FW-1:0]    fold_abs;
    logic signed [FW-1:0]    dp_fold;
    logic [EW1-1:0]          eta_mag;
    logic                    ok1;

    logic [DIST_W-1:0]       de_abs_reg;
    logic [DIST_W-1:0]       dp_abs_reg;
    logic                    ok1_reg;
    logic [SQ_W-1:0]         de2_reg;
    logic [SQ_W-1:0]         dp2_reg;
    logic                    ok2_reg;
    logic [D2_W-1:0]         d2_sum;
    logic [D2_W-1:0]         d2_reg;
    logic                    elig_reg;

    logic                    take;
    token_t                  tok_reg;
    logic [IDX_W-1:0]        idx_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (ctl.load && (count == MY_CNT))
        begin
            e_eta_reg <= bus.eta;
            e_phi_reg <= bus.phi;
            e_pt_reg  <= bus.pt;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (ctl.clr_used)
            used_next = 1'b0;
        else if (ctl.set_used && (tgt_idx == MY_IDX))
            used_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    // stage 1: absolute differences, phi folded past half a turn
    always_comb
    begin
        de      = EW1'(bus.eta) - EW1'(e_eta_reg);
        dp      = PW1'(bus.phi) - PW1'(e_phi_reg);
        de_mag  = de[EW1-1] ? EW1'(-de) : EW1'(de);
        dp_mag  = dp[PW1-1] ? PW1'(-dp) : PW1'(dp);
        dpx     = FW'(dp_mag);
        fold_v  = FW'(2 * HALF_TURN) - dpx;
        fold_abs = fold_v[FW-1] ? -fold_v : fold_v;
        dp_fold = (dpx > FW'(HALF_TURN)) ? fold_abs : dpx;
        eta_mag = e_eta_reg[ETA_W-1] ? EW1'(-EW1'(e_eta_reg)) : EW1'(e_eta_reg);
        ok1     = (MY_CNT < count) && !used_reg && (e_pt_reg > cfg.min_pt)
                  && (eta_mag < EW1'(cfg.eta_acc));
    end

    always_ff @(posedge clk)
    begin
        de_abs_reg <= de_mag[DIST_W-1:0];
        dp_abs_reg <= dp_fold[DIST_W-1:0];
        ok1_reg    <= ok1;
    end

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        de2_reg <= SQ_W'(de_abs_reg) * SQ_W'(de_abs_reg);
        dp2_reg <= SQ_W'(dp_abs_reg) * SQ_W'(dp_abs_reg);
        ok2_reg <= ok1_reg;
    end

    // stage 3: squared distance and cut
    assign d2_sum = D2_W'(de2_reg) + D2_W'(dp2_reg);

    always_ff @(posedge clk)
    begin
        d2_reg   <= d2_sum;
        elig_reg <= ok2_reg && (d2_sum < D2_W'(cfg.max_dr2));
    end

    // scan: strictly nearer replaces, so the lower index keeps a tie
    assign take = elig_reg && (!tok_in.have || (d2_reg < tok_in.d2));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg.have <= 1'b1;
            tok_reg.d2   <= d2_reg;
            idx_reg      <= MY_IDX;
        end
        else
        begin
            tok_reg <= tok_in;
            idx_reg <= idx_in;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
